// ===== hdl/mbe_pkg.sv =====
`default_nettype none

package mbe_pkg;

    // fixed-point layout of c and z: signed Q4.28
    localparam int unsigned FRAC_BITS = 28;
    localparam int unsigned COORD_W   = 13;
    localparam int unsigned STEP_W    = 28;

    // escape threshold 4.0 in Q8.56
    localparam logic [63:0] ESCAPE_SQ = 64'h0400_0000_0000_0000;

    // configuration register indexes
    localparam logic [2:0] CFG_X_ORIGIN = 3'd0;
    localparam logic [2:0] CFG_Y_ORIGIN = 3'd1;
    localparam logic [2:0] CFG_STEP_X   = 3'd2;
    localparam logic [2:0] CFG_STEP_Y   = 3'd3;
    localparam logic [2:0] CFG_MAX_ITER = 3'd4;

    // per-pixel payload moving down the cell chain
    typedef struct packed {
        logic signed [31:0]  zx;
        logic signed [31:0]  zy;
        logic signed [31:0]  cx;
        logic signed [31:0]  cy;
        logic                done;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
    } t_pix;

endpackage

`default_nettype wire

// ===== hdl/mandelbrot_escape_time_unit.sv =====
`default_nettype none

// Mandelbrot escape-time pixel unit.
// A pixel (column, row) is taken with start at any edge where busy is low;
// busy stays low, so a new pixel may be given in every cycle.
// The unit forms c = origin + index * step in signed Q4.28 and runs it down
// a chain of ITER_LIMIT cells, each doing one iteration z = z^2 + c in two
// register stages (products, then update and escape test). A pixel that has
// escaped or reached its bound rides the rest of the chain unchanged.
// The latency does not depend on the pixel; the chain length sets it.
// Throughput: one pixel per cycle.
// Results appear for one cycle with o_strobe, carrying the iteration count
// and the echoed coordinate, in input order. The receiver cannot stall.
// Configuration writes (index, data) are taken whenever i_cfg_valid is high;
// change them only while no pixel is in flight.
// Synchronous reset empties the chain and loads the default view.

module mandelbrot_escape_time_unit #(
    parameter int IMAGE_DIM  = 8192,
    parameter int ITER_LIMIT = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [12:0] i_pixel_col,
    input  wire logic [12:0] i_pixel_row,
    output logic             o_strobe,
    output logic [7:0]       o_iter_count,
    output logic [12:0]      o_out_col,
    output logic [12:0]      o_out_row,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import mbe_pkg::*;

    localparam int CW  = $clog2(ITER_LIMIT + 1);
    localparam int LAT = 2 * ITER_LIMIT + 2;

    logic signed [31:0]  r_x_origin;
    logic signed [31:0]  r_y_origin;
    logic [STEP_W-1:0]   r_step_x;
    logic [STEP_W-1:0]   r_step_y;
    logic [7:0]          r_max_iter;

    logic                ch_valid [0:ITER_LIMIT];
    t_pix                ch_data  [0:ITER_LIMIT];
    logic [CW-1:0]       ch_count [0:ITER_LIMIT];
    logic [CW-1:0]       ch_bound [0:ITER_LIMIT];

    logic                r_strobe;
    logic [7:0]          r_iter_count;
    logic [12:0]         r_out_col;
    logic [12:0]         r_out_row;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= -32'sd563714458;
            r_y_origin <= -32'sd348966093;
            r_step_x   <= STEP_W'(101581);
            r_step_y   <= STEP_W'(85197);
            r_max_iter <= 8'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_X_ORIGIN: r_x_origin <= signed'(i_cfg_data);
                CFG_Y_ORIGIN: r_y_origin <= signed'(i_cfg_data);
                CFG_STEP_X:   r_step_x   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:   r_step_y   <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // point c from the pixel coordinate
    mbe_coord #(
        .IMAGE_DIM  (IMAGE_DIM),
        .ITER_LIMIT (ITER_LIMIT)
    ) u_coord (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_col      (i_pixel_col),
        .i_row      (i_pixel_row),
        .i_x_origin (r_x_origin),
        .i_y_origin (r_y_origin),
        .i_step_x   (r_step_x),
        .i_step_y   (r_step_y),
        .i_max_iter (r_max_iter),
        .o_valid    (ch_valid[0]),
        .o_data     (ch_data[0]),
        .o_bound    (ch_bound[0])
    );

    assign ch_count[0] = '0;

    // chain of iteration cells
    for (genvar k = 0; k < ITER_LIMIT; k++) begin : g_cell
        mbe_cell #(
            .ITER_LIMIT (ITER_LIMIT)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (ch_valid[k]),
            .i_data  (ch_data[k]),
            .i_count (ch_count[k]),
            .i_bound (ch_bound[k]),
            .o_valid (ch_valid[k+1]),
            .o_data  (ch_data[k+1]),
            .o_count (ch_count[k+1]),
            .o_bound (ch_bound[k+1])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ch_valid[ITER_LIMIT];
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter_count <= 8'(ch_count[ITER_LIMIT]);
        r_out_col    <= ch_data[ITER_LIMIT].col;
        r_out_row    <= ch_data[ITER_LIMIT].row;
    end

    assign o_strobe     = r_strobe;
    assign o_iter_count = r_iter_count;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;

    // checks
    a_count_in_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ch_valid[ITER_LIMIT] |-> (ch_count[ITER_LIMIT] <= ch_bound[ITER_LIMIT]))
        else $error("iteration count above its bound");

    a_result_has_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result without a matching start");

    a_echo_col : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out_col == $past(i_pixel_col, LAT)))
        else $error("echoed column does not match");

endmodule

`default_nettype wire

// ===== hdl/mbe_coord.sv =====
`default_nettype none

module mbe_coord #(
    parameter int IMAGE_DIM  = 8192,
    parameter int ITER_LIMIT = 128
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_valid,
    input  wire logic [mbe_pkg::COORD_W-1:0]                i_col,
    input  wire logic [mbe_pkg::COORD_W-1:0]                i_row,
    input  wire logic signed [31:0]                         i_x_origin,
    input  wire logic signed [31:0]                         i_y_origin,
    input  wire logic [mbe_pkg::STEP_W-1:0]                 i_step_x,
    input  wire logic [mbe_pkg::STEP_W-1:0]                 i_step_y,
    input  wire logic [7:0]                                 i_max_iter,
    output logic                                            o_valid,
    output mbe_pkg::t_pix                                   o_data,
    output logic [$clog2(ITER_LIMIT+1)-1:0]                 o_bound
);
    import mbe_pkg::*;

    localparam int CW = $clog2(ITER_LIMIT + 1);
    localparam int BW = (CW > 8) ? CW : 8;
    localparam int PW = COORD_W + STEP_W;

    logic [COORD_W-1:0] col_idx;
    logic [COORD_W-1:0] row_idx;
    logic [PW-1:0]      prod_x;
    logic [PW-1:0]      prod_y;
    logic [BW-1:0]      mi_ext;
    logic [BW-1:0]      lim_ext;
    logic [CW-1:0]      bound;

    logic               r_valid;
    t_pix               r_data;
    logic [CW-1:0]      r_bound;

    // clamp indexes to the image, then origin + index * step
    always_comb begin
        col_idx = (32'(i_col) >= 32'(IMAGE_DIM)) ? COORD_W'(IMAGE_DIM - 1) : i_col;
        row_idx = (32'(i_row) >= 32'(IMAGE_DIM)) ? COORD_W'(IMAGE_DIM - 1) : i_row;
        prod_x  = PW'(col_idx) * PW'(i_step_x);
        prod_y  = PW'(row_idx) * PW'(i_step_y);
        mi_ext  = BW'(i_max_iter);
        lim_ext = BW'(ITER_LIMIT);
        bound   = CW'((mi_ext > lim_ext) ? lim_ext : mi_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload, z starts at zero
    always_ff @(posedge i_clk) begin
        r_data.zx   <= '0;
        r_data.zy   <= '0;
        r_data.cx   <= i_x_origin + signed'(prod_x[31:0]);
        r_data.cy   <= i_y_origin + signed'(prod_y[31:0]);
        r_data.done <= 1'b0;
        r_data.col  <= i_col;
        r_data.row  <= i_row;
        r_bound     <= bound;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_bound = r_bound;

endmodule

`default_nettype wire

// ===== hdl/mbe_cell.sv =====
`default_nettype none

module mbe_cell #(
    parameter int ITER_LIMIT = 128
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire mbe_pkg::t_pix                       i_data,
    input  wire logic [$clog2(ITER_LIMIT+1)-1:0]     i_count,
    input  wire logic [$clog2(ITER_LIMIT+1)-1:0]     i_bound,
    output logic                                     o_valid,
    output mbe_pkg::t_pix                            o_data,
    output logic [$clog2(ITER_LIMIT+1)-1:0]          o_count,
    output logic [$clog2(ITER_LIMIT+1)-1:0]          o_bound
);
    import mbe_pkg::*;

    localparam int CW = $clog2(ITER_LIMIT + 1);

    logic signed [31:0] zx;
    logic signed [31:0] zy;

    // product stage
    logic               r_a_valid;
    t_pix               r_a_data;
    logic [CW-1:0]      r_a_count;
    logic [CW-1:0]      r_a_bound;
    logic signed [63:0] r_xx;
    logic signed [63:0] r_yy;
    logic signed [63:0] r_xy;

    // update stage
    logic               r_b_valid;
    t_pix               r_b_data;
    logic [CW-1:0]      r_b_count;
    logic [CW-1:0]      r_b_bound;

    logic [63:0]        mag_sq;
    logic signed [63:0] diff;
    logic               go;
    t_pix               n_data;
    logic [CW-1:0]      n_count;

    assign zx = i_data.zx;
    assign zy = i_data.zy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    // exact Q8.56 squares and cross product
    always_ff @(posedge i_clk) begin
        r_a_data  <= i_data;
        r_a_count <= i_count;
        r_a_bound <= i_bound;
        r_xx      <= zx * zx;
        r_yy      <= zy * zy;
        r_xy      <= zx * zy;
    end

    // escape test and one iteration of z = z^2 + c
    always_comb begin
        mag_sq  = $unsigned(r_xx) + $unsigned(r_yy);
        diff    = r_xx - r_yy;
        go      = !r_a_data.done && (r_a_count < r_a_bound) && (mag_sq < ESCAPE_SQ);
        n_data  = r_a_data;
        n_count = r_a_count;
        if (go) begin
            n_data.zx = signed'(diff[59:28]) + r_a_data.cx;
            n_data.zy = signed'(r_xy[58:27]) + r_a_data.cy;
            n_count   = r_a_count + CW'(1);
        end else begin
            n_data.done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_data  <= n_data;
        r_b_count <= n_count;
        r_b_bound <= r_a_bound;
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;
    assign o_count = r_b_count;
    assign o_bound = r_b_bound;

endmodule

`default_nettype wire

// ===== tb/mandelbrot_escape_time_unit_checker.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_time_unit_checker #(
    parameter int IMAGE_DIM  = 8192,
    parameter int ITER_LIMIT = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [12:0] i_pixel_col,
    input  wire logic [12:0] i_pixel_row,
    input  wire logic        i_strobe,
    input  wire logic [7:0]  i_iter_count,
    input  wire logic [12:0] i_out_col,
    input  wire logic [12:0] i_out_row,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_pending,
    output int               o_fail_count
);

    import mbe_pkg::*;

    // view loaded by reset
    localparam int          DEFAULT_X_ORIGIN = -563714458;
    localparam int          DEFAULT_Y_ORIGIN = -348966093;
    localparam logic [27:0] DEFAULT_STEP_X   = 28'd101581;
    localparam logic [27:0] DEFAULT_STEP_Y   = 28'd85197;
    localparam logic [7:0]  DEFAULT_MAX_ITER = 8'd100;

    typedef struct packed {
        logic [7:0]  count;
        logic [12:0] col;
        logic [12:0] row;
    } t_pixel_result;

    t_pixel_result      expected_pixels[$];
    int                 x_origin;
    int                 y_origin;
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
    logic [7:0]         max_iter;
    int                 fail_count = 0;

    // escape-time count of one pixel under the current view
    function automatic logic [7:0] escape_count(input logic [12:0] col,
                                                input logic [12:0] row);
        int     bound;
        int     count;
        bit     escaped;
        longint col_c;
        longint row_c;
        longint cx;
        longint cy;
        longint zx;
        longint zy;
        longint re_sq;
        longint im_2;
        bound = (max_iter > ITER_LIMIT) ? ITER_LIMIT : int'(max_iter);
        col_c = (col >= IMAGE_DIM) ? IMAGE_DIM - 1 : longint'(col);
        row_c = (row >= IMAGE_DIM) ? IMAGE_DIM - 1 : longint'(row);
        // c wraps to 32 bits like the datapath does
        cx = longint'(int'(longint'(x_origin) + col_c * longint'(step_x)));
        cy = longint'(int'(longint'(y_origin) + row_c * longint'(step_y)));
        zx = 0;
        zy = 0;
        count = 0;
        escaped = 1'b0;
        while (count < bound && !escaped) begin
            // exact Q8.56 magnitude against 4.0
            if (zx * zx + zy * zy >= ESCAPE_SQ) begin
                escaped = 1'b1;
            end else begin
                re_sq = (zx * zx - zy * zy) >>> FRAC_BITS;
                im_2  = (2 * zx * zy) >>> FRAC_BITS;
                zx = longint'(int'(re_sq + cx));
                zy = longint'(int'(im_2 + cy));
                count++;
            end
        end
        return 8'(count);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // track config, predict on each pixel transfer, compare each result
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            x_origin = DEFAULT_X_ORIGIN;
            y_origin = DEFAULT_Y_ORIGIN;
            step_x   = DEFAULT_STEP_X;
            step_y   = DEFAULT_STEP_Y;
            max_iter = DEFAULT_MAX_ITER;
            expected_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_X_ORIGIN: x_origin = int'(i_cfg_data);
                    CFG_Y_ORIGIN: y_origin = int'(i_cfg_data);
                    CFG_STEP_X:   step_x   = i_cfg_data[STEP_W-1:0];
                    CFG_STEP_Y:   step_y   = i_cfg_data[STEP_W-1:0];
                    CFG_MAX_ITER: max_iter = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_strobe) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result with no pixel waiting, count",
                                    32'(i_iter_count), 32'd0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_iter_count !== want.count)
                        report_mismatch("iteration count", 32'(i_iter_count),
                                        32'(want.count));
                    if (i_out_col !== want.col)
                        report_mismatch("echoed column", 32'(i_out_col), 32'(want.col));
                    if (i_out_row !== want.row)
                        report_mismatch("echoed row", 32'(i_out_row), 32'(want.row));
                end
            end
            if (i_start && !i_busy) begin
                want.count = escape_count(i_pixel_col, i_pixel_row);
                want.col   = i_pixel_col;
                want.row   = i_pixel_row;
                expected_pixels = {expected_pixels, want};
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/mandelbrot_escape_time_unit_test.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_time_unit_test;

    import mbe_pkg::*;

    localparam int         IMAGE_DIM        = 8192;
    localparam int         ITER_LIMIT       = 128;
    localparam int         PIPE_LATENCY     = 2 * ITER_LIMIT + 2;
    localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CFG_LAST_UNUSED  = 3'd7;
    localparam int         COORD_MAX        = IMAGE_DIM - 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [12:0] i_pixel_col;
    logic [12:0] i_pixel_row;
    logic        o_strobe;
    logic [7:0]  o_iter_count;
    logic [12:0] o_out_col;
    logic [12:0] o_out_row;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          pending;
    int          fail_count;
    int          pixels_sent = 0;
    int          views_loaded = 0;

    always #1 i_clk = ~i_clk;

    mandelbrot_escape_time_unit #(
        .IMAGE_DIM  (IMAGE_DIM),
        .ITER_LIMIT (ITER_LIMIT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .o_strobe     (o_strobe),
        .o_iter_count (o_iter_count),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    mandelbrot_escape_time_unit_checker #(
        .IMAGE_DIM  (IMAGE_DIM),
        .ITER_LIMIT (ITER_LIMIT)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_strobe     (o_strobe),
        .i_iter_count (o_iter_count),
        .i_out_col    (o_out_col),
        .i_out_row    (o_out_row),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // one pixel transfer; start stays high for a following pixel
    task automatic send_pixel(input logic [12:0] col, input logic [12:0] row);
        start       <= 1'b1;
        i_pixel_col <= col;
        i_pixel_row <= row;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pixels_sent++;
    endtask

    // sender stays idle 35 then 48 percent of the time, then never
    task automatic pixel_gap();
        int idle_pct;
        idle_pct = (pixels_sent < 290) ? 35 : (pixels_sent < 580) ? 48 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int n);
        repeat (n) begin
            send_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            pixel_gap();
        end
    endtask

    // hold off until every pixel in flight has come back
    task automatic wait_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // new view, loaded only with the chain empty
    task automatic load_view(input logic [31:0] x0, input logic [31:0] y0,
                             input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] iter_bound);
        wait_results();
        write_reg(CFG_X_ORIGIN, x0);
        write_reg(CFG_Y_ORIGIN, y0);
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
        write_reg(CFG_MAX_ITER, iter_bound);
        // unmapped index must leave the view alone
        write_reg(3'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)), $urandom());
        i_cfg_valid <= 1'b0;
        views_loaded++;
    endtask

    // random view around the set, junk in the unused data bits
    task automatic load_random_view();
        load_view($urandom_range(0, 3 << 28) - (5 << 27),
                  $urandom_range(0, 3 << 28) - (3 << 27),
                  $urandom_range(1, 1 << 17) | ($urandom() & 32'hF000_0000),
                  $urandom_range(1, 1 << 17) | ($urandom() & 32'hF000_0000),
                  $urandom_range(1, ITER_LIMIT) | ($urandom() & 32'hFFFF_FF00));
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_pixel_col <= '0;
        i_pixel_row <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset view: image corners, bit patterns, inside and outside points
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(0, COORD_MAX);
        send_pixel(COORD_MAX, 0);
        send_pixel(13'h1555, 13'h0AAA);
        send_pixel(13'h0AAA, 13'h1555);
        send_pixel(4096, 4096);
        send_pixel(5549, 4096);
        send_pixel(2000, 4096);
        send_pixel(7000, 4096);
        send_random(150);

        // zero bound: nothing iterates
        load_view(-563714458, -348966093, 101581, 85197, 0);
        send_random(20);

        // bound above the chain length saturates
        load_view(-563714458, -348966093, 101581, 85197, 255);
        send_random(120);

        // c wraps past the Q4.28 range
        load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h0FFF_FFFF, 32'h0FFF_FFFF, 1);
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);
        send_random(60);
        load_view(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, ITER_LIMIT);
        send_pixel(COORD_MAX, 0);
        send_pixel(0, COORD_MAX);
        send_random(40);

        // deep zoom at the boundary, full bound
        load_view(-201326592, 26843546, 2000, 2000, ITER_LIMIT);
        send_random(150);

        repeat (4) begin
            load_random_view();
            send_random(75);
        end

        // fully random registers
        repeat (2) begin
            load_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            send_random(25);
        end

        wait_results();
        repeat (PIPE_LATENCY + 16) @(posedge i_clk);
        $display("covered %0d pixels over %0d views: zero, saturated and wrapping cases",
                 pixels_sent, views_loaded + 1);
        if (fail_count == 0)
            $display("[mandelbrot_escape_time_unit] OK");
        else
            $display("[mandelbrot_escape_time_unit] ERROR");
        $finish;
    end

    // hang guard
    initial begin
        #500000;
        $display("[mandelbrot_escape_time_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mbe_pkg.sv
hdl/mbe_coord.sv
hdl/mbe_cell.sv
hdl/mandelbrot_escape_time_unit.sv
tb/mandelbrot_escape_time_unit_checker.sv
tb/mandelbrot_escape_time_unit_test.sv
